/* hdl/lkv_pkg.sv */
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic hit;
    logic insert;
    logic evict;
    logic write_value;
  } lkv_ctrl_t;

endpackage

/* hdl/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// A request is taken on a rising edge where start is high and busy is low; busy
// stays low, so a request may be issued every cycle. op selects get or put,
// lookup_key is the key and put_value the data stored by a put.
// The request is registered, then compared against all entries in parallel and
// the recency ranks are updated in the next cycle, and the result is
// registered. done is registered from the request valid together with the
// result and carries hit, read_value, evicted and evicted_key. Throughput is
// one request per cycle; the parallel key compare and rank update never stall.
// The receiver cannot stall; every result is shown for exactly one cycle.
// The capacity register is written through cfg_valid/cfg_ready/cfg_capacity
// and should only be changed while no request is in flight.
// Reset empties the cache and sets the capacity to 16 entries.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   op,
  input  logic signed [lkv_pkg::DATA_W-1:0]      lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0]      put_value,
  output logic                                   done,
  output logic                                   hit,
  output logic signed [lkv_pkg::DATA_W-1:0]      read_value,
  output logic                                   evicted,
  output logic signed [lkv_pkg::DATA_W-1:0]      evicted_key,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [lkv_pkg::CAP_W-1:0]       cfg_capacity
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);

  logic                        req_valid;
  logic                        req_op;
  logic [lkv_pkg::DATA_W-1:0]  req_key;
  logic [lkv_pkg::DATA_W-1:0]  req_value;
  logic [lkv_pkg::CAP_W-1:0]   capacity;

  logic [lkv_pkg::DATA_W-1:0]  keys [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0]  values [ENTRIES];
  logic [ENTRIES-1:0]          valid;
  logic [RANK_W-1:0]           ranks [ENTRIES];
  logic [FILL_W-1:0]           fill;

  lkv_pkg::lkv_ctrl_t          ctrl;
  logic [ENTRIES-1:0]          slot_oh;
  logic [RANK_W-1:0]           pivot_rank;
  logic [lkv_pkg::DATA_W-1:0]  lk_read_value;
  logic [lkv_pkg::DATA_W-1:0]  lk_evicted_key;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_op <= op;
      req_key <= lookup_key;
      req_value <= put_value;
    end
  end

  lkv_lookup #(
    .ENTRIES(ENTRIES),
    .RANK_W (RANK_W),
    .FILL_W (FILL_W)
  ) u_lookup (
    .op         (req_op),
    .lookup_key (req_key),
    .capacity   (capacity),
    .keys       (keys),
    .values     (values),
    .valid      (valid),
    .ranks      (ranks),
    .fill       (fill),
    .ctrl       (ctrl),
    .slot_oh    (slot_oh),
    .pivot_rank (pivot_rank),
    .read_value (lk_read_value),
    .evicted_key(lk_evicted_key)
  );

  lkv_store #(
    .ENTRIES(ENTRIES),
    .RANK_W (RANK_W),
    .FILL_W (FILL_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_key   (req_key),
    .req_value (req_value),
    .ctrl      (ctrl),
    .slot_oh   (slot_oh),
    .pivot_rank(pivot_rank),
    .keys      (keys),
    .values    (values),
    .valid     (valid),
    .ranks     (ranks),
    .fill      (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      hit <= ctrl.hit;
      read_value <= lk_read_value;
      evicted <= ctrl.evict;
      evicted_key <= lk_evicted_key;
    end
  end

endmodule

/* hdl/lkv_lookup.sv */
`timescale 1ns / 1ps

module lkv_lookup #(
  parameter int ENTRIES = 16,
  parameter int RANK_W = 4,
  parameter int FILL_W = 5
) (
  input  logic                              op,
  input  logic        [lkv_pkg::DATA_W-1:0] lookup_key,
  input  logic        [lkv_pkg::CAP_W-1:0]  capacity,
  input  logic        [lkv_pkg::DATA_W-1:0] keys [ENTRIES],
  input  logic        [lkv_pkg::DATA_W-1:0] values [ENTRIES],
  input  logic        [ENTRIES-1:0]         valid,
  input  logic        [RANK_W-1:0]          ranks [ENTRIES],
  input  logic        [FILL_W-1:0]          fill,
  output lkv_pkg::lkv_ctrl_t                ctrl,
  output logic        [ENTRIES-1:0]         slot_oh,
  output logic        [RANK_W-1:0]          pivot_rank,
  output logic        [lkv_pkg::DATA_W-1:0] read_value,
  output logic        [lkv_pkg::DATA_W-1:0] evicted_key
);

  localparam int CMP_W = (FILL_W > lkv_pkg::CAP_W) ? FILL_W : lkv_pkg::CAP_W;

  logic [ENTRIES-1:0] hit_oh;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] free_oh;
  logic               found;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic [RANK_W-1:0]  oldest_rank;
  logic [lkv_pkg::DATA_W-1:0] hit_value;
  logic [FILL_W-1:0]  fill_m1;

  always_comb begin
    cap_eff = CMP_W'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
    full = CMP_W'(fill) >= cap_eff;
    fill_m1 = fill - FILL_W'(1);
    oldest_rank = RANK_W'(fill_m1);
  end

  always_comb begin
    found = 1'b0;
    hit_oh = '0;
    victim_oh = '0;
    free_oh = '0;
    pivot_rank = '0;
    hit_value = '0;
    evicted_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && (keys[i] == lookup_key) && !found) begin
        hit_oh[i] = 1'b1;
        found = 1'b1;
      end
      victim_oh[i] = valid[i] && (ranks[i] == oldest_rank);
      free_oh[i] = (fill == FILL_W'(i));
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        pivot_rank = pivot_rank | ranks[i];
        hit_value = hit_value | values[i];
      end
    end
    ctrl.hit = found;
    ctrl.insert = (op == lkv_pkg::OP_PUT) && !found;
    ctrl.evict = ctrl.insert && full;
    ctrl.write_value = (op == lkv_pkg::OP_PUT);
    for (int i = 0; i < ENTRIES; i++) begin
      if (ctrl.evict && victim_oh[i]) begin
        evicted_key = evicted_key | keys[i];
      end
    end
    if (found) begin
      slot_oh = hit_oh;
    end else if (full) begin
      slot_oh = victim_oh;
    end else begin
      slot_oh = free_oh;
    end
    read_value = (found && (op == lkv_pkg::OP_GET)) ? hit_value : '0;
  end

endmodule

/* hdl/lkv_store.sv */
`timescale 1ns / 1ps

module lkv_store #(
  parameter int ENTRIES = 16,
  parameter int RANK_W = 4,
  parameter int FILL_W = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic        [lkv_pkg::DATA_W-1:0] req_key,
  input  logic        [lkv_pkg::DATA_W-1:0] req_value,
  input  lkv_pkg::lkv_ctrl_t                ctrl,
  input  logic        [ENTRIES-1:0]         slot_oh,
  input  logic        [RANK_W-1:0]          pivot_rank,
  output logic        [lkv_pkg::DATA_W-1:0] keys [ENTRIES],
  output logic        [lkv_pkg::DATA_W-1:0] values [ENTRIES],
  output logic        [ENTRIES-1:0]         valid,
  output logic        [RANK_W-1:0]          ranks [ENTRIES],
  output logic        [FILL_W-1:0]          fill
);

  logic promote;

  assign promote = req_valid && (ctrl.hit || ctrl.insert);

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (req_valid && slot_oh[i]) begin
        if (ctrl.insert) begin
          keys[i] <= req_key;
        end
        if (ctrl.write_value) begin
          values[i] <= req_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      if (req_valid && ctrl.insert) begin
        valid <= valid | slot_oh;
        if (!ctrl.evict && (fill < FILL_W'(ENTRIES))) begin
          fill <= fill + FILL_W'(1);
        end
      end
      if (promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            ranks[i] <= '0;
          end else if (valid[i] && (ctrl.insert || (ranks[i] < pivot_rank))) begin
            ranks[i] <= ranks[i] + RANK_W'(1);
          end
        end
      end
    end
  end

endmodule

/* sim/lru_key_value_cache_test.sv */
`timescale 1ns / 1ps

module lru_key_value_cache_test;

  localparam int ENTRIES = 16;

  typedef struct packed {
    logic                              hit;
    logic signed [lkv_pkg::DATA_W-1:0] rd_value;
    logic                              ev;
    logic signed [lkv_pkg::DATA_W-1:0] ev_key;
  } cache_result_t;

  typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic                        op;
    logic [lkv_pkg::DATA_W-1:0]  key;
    logic [lkv_pkg::DATA_W-1:0]  value;
    logic [lkv_pkg::CAP_W-1:0]   capacity;
    bit                          typed;
    cache_result_t               want;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              op = lkv_pkg::OP_GET;
  logic signed [lkv_pkg::DATA_W-1:0] lookup_key = '0;
  logic signed [lkv_pkg::DATA_W-1:0] put_value = '0;
  logic                              done;
  logic                              hit;
  logic signed [lkv_pkg::DATA_W-1:0] read_value;
  logic                              evicted;
  logic signed [lkv_pkg::DATA_W-1:0] evicted_key;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lkv_pkg::CAP_W-1:0]         cfg_capacity = '0;

  logic [lkv_pkg::DATA_W-1:0] ent_key [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] ent_val [ENTRIES];
  bit                         ent_valid [ENTRIES];
  int                         ent_rank [ENTRIES];
  int                         fill_cnt = 0;
  logic [lkv_pkg::CAP_W-1:0]  cap_reg = lkv_pkg::CAP_RESET;

  cache_result_t pending_results[$];
  plan_row_t     plan[$];
  logic [lkv_pkg::DATA_W-1:0] hot_keys[$];
  int failures = 0;
  bit no_idle = 1'b0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .lookup_key(lookup_key),
    .put_value(put_value),
    .done(done),
    .hit(hit),
    .read_value(read_value),
    .evicted(evicted),
    .evicted_key(evicted_key),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void promote(int s, int old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && ent_valid[i] && ent_rank[i] < old_rank) ent_rank[i]++;
    end
    ent_rank[s] = 0;
  endfunction

  function automatic cache_result_t cache_access(logic op_i,
                                                 logic [lkv_pkg::DATA_W-1:0] key_i,
                                                 logic [lkv_pkg::DATA_W-1:0] val_i);
    cache_result_t r;
    int found;
    int slot;
    int eff;
    int old_rank;
    int best;
    bit have;
    r = '0;
    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && ent_valid[i] && ent_key[i] == key_i) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op_i == lkv_pkg::OP_GET) r.rd_value = ent_val[found];
      else ent_val[found] = val_i;
      promote(found, ent_rank[found]);
    end else if (op_i == lkv_pkg::OP_PUT) begin
      eff = (cap_reg == 0) ? 1 : ((int'(cap_reg) > ENTRIES) ? ENTRIES : int'(cap_reg));
      have = 1'b0;
      slot = 0;
      best = 0;
      old_rank = 1 << 30;
      if (fill_cnt >= eff) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (ent_valid[i] && (!have || ent_rank[i] >= best)) begin
            best = ent_rank[i];
            slot = i;
            have = 1'b1;
          end
        end
        if (have) begin
          r.ev = 1'b1;
          r.ev_key = ent_key[slot];
          old_rank = ent_rank[slot];
        end
      end
      if (!have) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!have && !ent_valid[i]) begin
            slot = i;
            have = 1'b1;
          end
        end
        if (have && fill_cnt < ENTRIES) fill_cnt++;
        old_rank = 1 << 30;
      end
      if (have) begin
        ent_valid[slot] = 1'b1;
        ent_key[slot] = key_i;
        ent_val[slot] = val_i;
        promote(slot, old_rank);
      end
    end
    return r;
  endfunction

  function automatic plan_row_t req(logic op_i, logic [lkv_pkg::DATA_W-1:0] key_i,
                                    logic [lkv_pkg::DATA_W-1:0] val_i);
    plan_row_t row;
    row.kind = ROW_REQUEST;
    row.op = op_i;
    row.key = key_i;
    row.value = val_i;
    row.capacity = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t known(logic op_i, logic [lkv_pkg::DATA_W-1:0] key_i,
                                      logic [lkv_pkg::DATA_W-1:0] val_i, logic h,
                                      logic [lkv_pkg::DATA_W-1:0] rd);
    plan_row_t row;
    row = req(op_i, key_i, val_i);
    row.typed = 1'b1;
    row.want = '{hit: h, rd_value: rd, ev: 1'b0, ev_key: '0};
    return row;
  endfunction

  function automatic plan_row_t cap_row(logic [lkv_pkg::CAP_W-1:0] v);
    plan_row_t row;
    row = req(lkv_pkg::OP_GET, '0, '0);
    row.kind = ROW_CAPACITY;
    row.capacity = v;
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  task automatic issue_request(input logic op_i, input logic [lkv_pkg::DATA_W-1:0] key_i,
                               input logic [lkv_pkg::DATA_W-1:0] val_i, input bit typed,
                               input cache_result_t want);
    cache_result_t pred;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= op_i;
    lookup_key <= key_i;
    put_value <= val_i;
    do @(posedge clk); while (busy);
    pred = cache_access(op_i, key_i, val_i);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  always @(posedge clk) begin
    cache_result_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("%0t: result with no request pending", $realtime));
      end else begin
        w = pending_results.pop_front();
        if (hit !== w.hit || read_value !== w.rd_value || evicted !== w.ev ||
            evicted_key !== w.ev_key) begin
          note_failure($sformatf(
            "%0t: mismatch exp hit=%b rd=%h ev=%b evk=%h got hit=%b rd=%h ev=%b evk=%h",
            $realtime, w.hit, w.rd_value, w.ev, w.ev_key,
            hit, read_value, evicted, evicted_key));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [lkv_pkg::CAP_W-1:0] caps[10];
    logic [lkv_pkg::DATA_W-1:0] key;
    int pool;
    int r;
    plan_row_t row;

    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_rank[i] = 0;
    end

    plan.push_back(known(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0));
    plan.push_back(known(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(known(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0));
    plan.push_back(known(lkv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(known(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0));
    plan.push_back(known(lkv_pkg::OP_GET, 32'h8000_0000, 32'h1234_5678, 1'b1,
                         32'h7FFF_FFFF));
    plan.push_back(known(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                         32'h8000_0000));
    plan.push_back(known(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
                         32'hFFFF_FFFF));
    plan.push_back(known(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '0));
    plan.push_back(known(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
                         32'h5A5A_5A5A));
    plan.push_back(known(lkv_pkg::OP_GET, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(cap_row(5'd4));
    plan.push_back(req(lkv_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0001));
    plan.push_back(req(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000));
    plan.push_back(cap_row(5'd2));
    plan.push_back(req(lkv_pkg::OP_PUT, 32'h0000_0002, 32'h0000_0002));
    plan.push_back(req(lkv_pkg::OP_PUT, 32'h0000_0003, 32'h0000_0003));
    plan.push_back(req(lkv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000));
    plan.push_back(cap_row(5'd0));
    plan.push_back(req(lkv_pkg::OP_PUT, 32'hA5A5_A5A5, 32'h3C3C_3C3C));
    plan.push_back(req(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    plan.push_back(cap_row(5'd31));
    plan.push_back(req(lkv_pkg::OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA));
    plan.push_back(req(lkv_pkg::OP_GET, 32'h5555_5555, 32'h0000_0000));
    plan.push_back(req(lkv_pkg::OP_GET, 32'hA5A5_A5A5, 32'h0000_0000));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CAPACITY) write_capacity(row.capacity);
      else issue_request(row.op, row.key, row.value, row.typed, row.want);
    end

    caps = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16, 5'd5, 5'd0};
    caps[9] = $urandom_range(0, 31);
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      no_idle = ($urandom_range(0, 3) == 0);
      pool = ((caps[p] == 0) ? 1 : ((caps[p] > ENTRIES) ? ENTRIES : int'(caps[p]))) +
             $urandom_range(1, 6);
      hot_keys.delete();
      repeat (pool) hot_keys.push_back($urandom);
      repeat (55) begin
        r = $urandom_range(0, 99);
        if (r < 85) key = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
        else if (r < 90) key = (r < 88) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else key = $urandom;
        issue_request(logic'($urandom_range(0, 1)), key, $urandom, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) note_failure("requests left without a result");

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
